[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication check: when the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

[design/cmsu_pkg.sv]
// Package: opcodes, widths and shared types of the alignment-operation merge unit.
`default_nettype none
package cmsu_pkg;

   localparam int OP_BITS      = 4;
   localparam int OUT_LEN_BITS = 28;
   localparam int STAT_BITS    = 32;
   localparam int CNT_BITS     = 16;

   localparam int LEN_BITS_DEF    = 28;
   localparam int SUM_BITS_DEF    = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [OP_BITS-1:0] OP_M  = 4'd0;
   localparam logic [OP_BITS-1:0] OP_I  = 4'd1;
   localparam logic [OP_BITS-1:0] OP_D  = 4'd2;
   localparam logic [OP_BITS-1:0] OP_N  = 4'd3;
   localparam logic [OP_BITS-1:0] OP_S  = 4'd4;
   localparam logic [OP_BITS-1:0] OP_H  = 4'd5;
   localparam logic [OP_BITS-1:0] OP_P  = 4'd6;
   localparam logic [OP_BITS-1:0] OP_EQ = 4'd7;
   localparam logic [OP_BITS-1:0] OP_X  = 4'd8;

   localparam logic [STAT_BITS-1:0] STAT_MAX = {STAT_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]  CNT_MAX  = {CNT_BITS{1'b1}};

   typedef struct packed {
      logic [STAT_BITS-1:0] aligned_bases;
      logic [STAT_BITS-1:0] ref_span;
      logic [CNT_BITS-1:0]  gap_count;
      logic [STAT_BITS-1:0] clipped_bases;
      logic                 odd_op_flag;
   } cmsu_stats_type;

   typedef struct packed {
      logic                    flush;
      logic [OUT_LEN_BITS-1:0] flush_length;
      logic [OP_BITS-1:0]      op;
      logic [OUT_LEN_BITS-1:0] length;
      logic                    last;
      cmsu_stats_type          stats;
   } cmsu_entry_type;

   typedef struct packed {
      logic           valid;
      cmsu_entry_type entry;
   } cmsu_push_type;

   typedef struct packed {
      logic [OP_BITS-1:0]      op;
      logic [OUT_LEN_BITS-1:0] length;
      logic                    last;
      cmsu_stats_type          stats;
      logic [CNT_BITS-1:0]     count;
   } cmsu_beat_type;

endpackage
`default_nettype wire

[design/cmsu_if.sv]
// Valid/ready channel interfaces for operation input and result output.
`default_nettype none
interface cmsu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cmsu_pkg::OP_BITS-1:0]         op_code;
   logic [cmsu_pkg::OUT_LEN_BITS-1:0]    op_length;
   logic                                 in_last;

   modport source (output valid, output op_code, output op_length, output in_last,
                   input ready);
   modport sink   (input valid, input op_code, input op_length, input in_last,
                   output ready);
endinterface

interface cmsu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cmsu_pkg::OP_BITS-1:0]         out_op;
   logic [cmsu_pkg::OUT_LEN_BITS-1:0]    out_length;
   logic                                 out_last;
   logic [cmsu_pkg::STAT_BITS-1:0]       aligned_bases;
   logic [cmsu_pkg::STAT_BITS-1:0]       ref_span;
   logic [cmsu_pkg::CNT_BITS-1:0]        gap_count;
   logic [cmsu_pkg::STAT_BITS-1:0]       clipped_bases;
   logic                                 odd_op_flag;
   logic [cmsu_pkg::CNT_BITS-1:0]        out_count;

   modport source (output valid, output out_op, output out_length, output out_last,
                   output aligned_bases, output ref_span, output gap_count,
                   output clipped_bases, output odd_op_flag, output out_count,
                   input ready);
   modport sink   (input valid, input out_op, input out_length, input out_last,
                   input aligned_bases, input ref_span, input gap_count,
                   input clipped_bases, input odd_op_flag, input out_count,
                   output ready);
endinterface
`default_nettype wire

[design/cmsu_front.sv]
// Front end: accepts operations, merges =/X runs, accumulates record statistics.
`default_nettype none
module cmsu_front #(
   parameter int LEN_BITS = cmsu_pkg::LEN_BITS_DEF,
   parameter int SUM_BITS = cmsu_pkg::SUM_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   cmsu_req_if.sink                req_chan,
   input  logic                    push_ready,
   output cmsu_pkg::cmsu_push_type push
);

   localparam int ADD_BITS  = ((SUM_BITS > LEN_BITS) ? SUM_BITS : LEN_BITS) + 1;
   localparam int WIDE_BITS = (SUM_BITS > cmsu_pkg::STAT_BITS) ? SUM_BITS
                                                              : cmsu_pkg::STAT_BITS;
   localparam int OL        = cmsu_pkg::OUT_LEN_BITS;
   localparam int SB        = cmsu_pkg::STAT_BITS;

   logic                merge_pending_ff, merge_pending_in;
   logic [LEN_BITS-1:0] merge_length_ff, merge_length_in;
   logic [SUM_BITS-1:0] aligned_sum_ff, aligned_sum_in;
   logic [SUM_BITS-1:0] span_sum_ff, span_sum_in;
   logic [SUM_BITS-1:0] clip_sum_ff, clip_sum_in;
   logic [cmsu_pkg::CNT_BITS-1:0] gap_tally_ff, gap_tally_in;
   logic                odd_seen_ff, odd_seen_in;

   logic [cmsu_pkg::OP_BITS-1:0] op;
   logic [LEN_BITS-1:0] len;
   logic                accept;
   logic                is_merge;
   logic                add_aligned, add_span, add_gap, add_clip, set_odd;
   logic [LEN_BITS-1:0] merge_sum;
   logic [LEN_BITS:0]   merge_raw;
   logic [SUM_BITS-1:0] aligned_nx, span_nx, clip_nx;
   logic [cmsu_pkg::CNT_BITS-1:0] gap_nx;
   logic                odd_nx;

   function automatic logic [SUM_BITS-1:0] sum_sat(input logic [SUM_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [ADD_BITS-1:0] s;
      s = ADD_BITS'(a) + ADD_BITS'(b);
      if (s > ADD_BITS'({SUM_BITS{1'b1}})) begin
         return {SUM_BITS{1'b1}};
      end
      return s[SUM_BITS-1:0];
   endfunction

   function automatic logic [SB-1:0] clamp(input logic [SUM_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      if (w > WIDE_BITS'(cmsu_pkg::STAT_MAX)) begin
         return cmsu_pkg::STAT_MAX;
      end
      return w[SB-1:0];
   endfunction

   assign op     = req_chan.op_code;
   assign len    = req_chan.op_length[LEN_BITS-1:0];
   assign accept = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;

   always_comb begin
      add_aligned = 1'b0;
      add_span    = 1'b0;
      add_gap     = 1'b0;
      add_clip    = 1'b0;
      set_odd     = 1'b0;
      unique case (op)
         cmsu_pkg::OP_M, cmsu_pkg::OP_EQ, cmsu_pkg::OP_X: begin
            add_aligned = 1'b1;
            add_span    = 1'b1;
         end
         cmsu_pkg::OP_I: begin
            add_aligned = 1'b1;
            add_gap     = 1'b1;
         end
         cmsu_pkg::OP_D: begin
            add_span = 1'b1;
            add_gap  = 1'b1;
         end
         cmsu_pkg::OP_N: add_span = 1'b1;
         cmsu_pkg::OP_S: add_clip = 1'b1;
         cmsu_pkg::OP_H: ;
         default:        set_odd = 1'b1;
      endcase
   end

   assign is_merge   = (op == cmsu_pkg::OP_EQ) || (op == cmsu_pkg::OP_X);
   assign aligned_nx = add_aligned ? sum_sat(aligned_sum_ff, len) : aligned_sum_ff;
   assign span_nx    = add_span ? sum_sat(span_sum_ff, len) : span_sum_ff;
   assign clip_nx    = add_clip ? sum_sat(clip_sum_ff, len) : clip_sum_ff;
   assign gap_nx     = (add_gap && (gap_tally_ff != cmsu_pkg::CNT_MAX))
                       ? gap_tally_ff + 1'b1 : gap_tally_ff;
   assign odd_nx     = odd_seen_ff || set_odd;

   assign merge_raw  = {1'b0, merge_length_ff} + {1'b0, len};
   assign merge_sum  = !merge_pending_ff ? len
                       : (merge_raw[LEN_BITS] ? {LEN_BITS{1'b1}} : merge_raw[LEN_BITS-1:0]);

   always_comb begin
      push.valid                     = accept && (!is_merge || req_chan.in_last);
      push.entry.flush               = !is_merge && merge_pending_ff;
      push.entry.flush_length        = OL'(merge_length_ff);
      push.entry.op                  = is_merge ? cmsu_pkg::OP_M : op;
      push.entry.length              = is_merge ? OL'(merge_sum) : OL'(len);
      push.entry.last                = req_chan.in_last;
      push.entry.stats.aligned_bases = clamp(aligned_nx);
      push.entry.stats.ref_span      = clamp(span_nx);
      push.entry.stats.gap_count     = gap_nx;
      push.entry.stats.clipped_bases = clamp(clip_nx);
      push.entry.stats.odd_op_flag   = odd_nx;
   end

   always_comb begin
      merge_pending_in = merge_pending_ff;
      merge_length_in  = merge_length_ff;
      aligned_sum_in   = aligned_sum_ff;
      span_sum_in      = span_sum_ff;
      clip_sum_in      = clip_sum_ff;
      gap_tally_in     = gap_tally_ff;
      odd_seen_in      = odd_seen_ff;
      if (accept) begin
         if (req_chan.in_last) begin
            merge_pending_in = 1'b0;
            merge_length_in  = '0;
            aligned_sum_in   = '0;
            span_sum_in      = '0;
            clip_sum_in      = '0;
            gap_tally_in     = '0;
            odd_seen_in      = 1'b0;
         end else begin
            aligned_sum_in   = aligned_nx;
            span_sum_in      = span_nx;
            clip_sum_in      = clip_nx;
            gap_tally_in     = gap_nx;
            odd_seen_in      = odd_nx;
            merge_pending_in = is_merge;
            merge_length_in  = is_merge ? merge_sum : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_pending_ff <= 1'b0;
         merge_length_ff  <= '0;
         aligned_sum_ff   <= '0;
         span_sum_ff      <= '0;
         clip_sum_ff      <= '0;
         gap_tally_ff     <= '0;
         odd_seen_ff      <= 1'b0;
      end else begin
         merge_pending_ff <= merge_pending_in;
         merge_length_ff  <= merge_length_in;
         aligned_sum_ff   <= aligned_sum_in;
         span_sum_ff      <= span_sum_in;
         clip_sum_ff      <= clip_sum_in;
         gap_tally_ff     <= gap_tally_in;
         odd_seen_ff      <= odd_seen_in;
      end
   end

endmodule
`default_nettype wire

[design/cmsu_queue.sv]
// Short FIFO of classified operations between front and back end.
`default_nettype none
module cmsu_queue #(
   parameter int DEPTH = cmsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmsu_pkg::cmsu_push_type push,
   output logic                    push_ready,
   output cmsu_pkg::cmsu_push_type head,
   input  logic                    pop
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   cmsu_pkg::cmsu_entry_type mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (fill_ff != '0);

   assign head.valid = (fill_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

[design/cmsu_back.sv]
// Back end: expands queued entries into result beats and counts emitted operations.
`default_nettype none
module cmsu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cmsu_pkg::cmsu_push_type head,
   output logic                    pop,
   cmsu_rsp_if.source              rsp_chan
);

   logic                    rsp_valid_ff, rsp_valid_in;
   cmsu_pkg::cmsu_beat_type beat_ff, beat_in;
   logic                    phase_ff, phase_in;
   logic [cmsu_pkg::CNT_BITS-1:0] tally_ff, tally_in;
   logic [cmsu_pkg::CNT_BITS-1:0] count;
   logic                    load;
   logic                    flush_beat;

   assign load       = !rsp_valid_ff || rsp_chan.ready;
   assign flush_beat = head.entry.flush && !phase_ff;
   assign count      = (tally_ff == cmsu_pkg::CNT_MAX) ? tally_ff : tally_ff + 1'b1;
   assign pop        = load && head.valid && !flush_beat;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      phase_in     = phase_ff;
      tally_in     = tally_ff;
      if (load) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            beat_in.stats = head.entry.stats;
            beat_in.count = count;
            if (flush_beat) begin
               beat_in.op     = cmsu_pkg::OP_M;
               beat_in.length = head.entry.flush_length;
               beat_in.last   = 1'b0;
               phase_in       = 1'b1;
               tally_in       = count;
            end else begin
               beat_in.op     = head.entry.op;
               beat_in.length = head.entry.length;
               beat_in.last   = head.entry.last;
               phase_in       = 1'b0;
               tally_in       = head.entry.last ? '0 : count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         tally_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         tally_ff     <= tally_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_op        = beat_ff.op;
   assign rsp_chan.out_length    = beat_ff.length;
   assign rsp_chan.out_last      = beat_ff.last;
   assign rsp_chan.aligned_bases = beat_ff.stats.aligned_bases;
   assign rsp_chan.ref_span      = beat_ff.stats.ref_span;
   assign rsp_chan.gap_count     = beat_ff.stats.gap_count;
   assign rsp_chan.clipped_bases = beat_ff.stats.clipped_bases;
   assign rsp_chan.odd_op_flag   = beat_ff.stats.odd_op_flag;
   assign rsp_chan.out_count     = beat_ff.count;

endmodule
`default_nettype wire

[design/cigar_merge_and_stats_unit.sv]
// Top level: alignment-operation normalizer with per-record statistics.
// Takes one operation per cycle on req_chan and merges runs of = and X into a single M,
// with saturating lengths; every result carries running record statistics (aligned
// bases, reference span, gap count, soft-clipped bases, odd-op flag, emitted count),
// final on the result with out_last set. An = or X that is not last gives no result;
// an operation that closes a pending run gives two results, so an item takes up to two
// transfers of the result port, which is the limit on sustained rate. A queue of
// QUEUE_DEPTH entries separates the front end from the result register; input is
// taken while the queue has room. No clearing pass after reset.
`default_nettype none
module cigar_merge_and_stats_unit #(
   parameter int LEN_BITS    = cmsu_pkg::LEN_BITS_DEF,
   parameter int SUM_BITS    = cmsu_pkg::SUM_BITS_DEF,
   parameter int QUEUE_DEPTH = cmsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cmsu_req_if.sink    req_chan,
   cmsu_rsp_if.source  rsp_chan
);

   cmsu_pkg::cmsu_push_type push;
   cmsu_pkg::cmsu_push_type head;
   logic                    push_ready;
   logic                    pop;

   cmsu_front #(
      .LEN_BITS (LEN_BITS),
      .SUM_BITS (SUM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push       (push)
   );

   cmsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   cmsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

[design/cmsu_checker.sv]
// Port-level checker for the merge unit and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module cmsu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [cmsu_pkg::OP_BITS-1:0]        rsp_out_op,
   input logic [cmsu_pkg::OUT_LEN_BITS-1:0]   rsp_out_length,
   input logic                                rsp_out_last,
   input logic [cmsu_pkg::CNT_BITS-1:0]       rsp_out_count
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_op) && $stable(rsp_out_length) && $stable(rsp_out_count)), "result changed while stalled")
   `ASSERT_IMPL(a_no_eq_x, clock, reset, rsp_valid, (rsp_out_op != cmsu_pkg::OP_EQ) && (rsp_out_op != cmsu_pkg::OP_X), "unmerged = or X on output")
   `ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_valid, rsp_out_count != '0, "emitted count is zero")
   `ASSERT_CLK(a_count_restart, clock, reset, (rsp_valid && rsp_ready && rsp_out_last) ##1 rsp_valid |-> (rsp_out_count == 16'd1), "count not restarted after record end")

endmodule

bind cigar_merge_and_stats_unit cmsu_checker u_cmsu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_op     (rsp_chan.out_op),
   .rsp_out_length (rsp_chan.out_length),
   .rsp_out_last   (rsp_chan.out_last),
   .rsp_out_count  (rsp_chan.out_count)
);
`default_nettype wire

[dv/cmsu_sb_pkg.sv]
// Scoreboard for the alignment-operation merge unit: expected-result predictor and result checks.
`timescale 1ns / 1ps
package cmsu_sb_pkg;
   import cmsu_pkg::*;

   localparam logic [OUT_LEN_BITS-1:0] LEN_MAX = {OUT_LEN_BITS{1'b1}};
   localparam int unsigned REPORT_LIMIT = 10;

   function automatic logic [STAT_BITS-1:0] sum_sat(input logic [STAT_BITS-1:0] acc,
                                                    input logic [OUT_LEN_BITS-1:0] len);
      logic [STAT_BITS:0] total;
      total = {1'b0, acc} + (STAT_BITS + 1)'(len);
      return total[STAT_BITS] ? STAT_MAX : total[STAT_BITS-1:0];
   endfunction

   function automatic logic [OUT_LEN_BITS-1:0] len_sat(input logic [OUT_LEN_BITS-1:0] acc,
                                                       input logic [OUT_LEN_BITS-1:0] len);
      logic [OUT_LEN_BITS:0] total;
      total = {1'b0, acc} + {1'b0, len};
      return total[OUT_LEN_BITS] ? LEN_MAX : total[OUT_LEN_BITS-1:0];
   endfunction

   function automatic logic [CNT_BITS-1:0] count_sat(input logic [CNT_BITS-1:0] acc);
      return (acc == CNT_MAX) ? acc : acc + 1'b1;
   endfunction

   function automatic string beat_text(input cmsu_beat_type b);
      return $sformatf("op %0d len %h last %b al %h span %h gap %0d clip %h odd %b cnt %0d",
                       b.op, b.length, b.last, b.stats.aligned_bases, b.stats.ref_span,
                       b.stats.gap_count, b.stats.clipped_bases, b.stats.odd_op_flag, b.count);
   endfunction

   class cigar_stats_scoreboard;
      cmsu_beat_type           expected_beats[$];
      bit                      run_open;
      logic [OUT_LEN_BITS-1:0] run_length;
      cmsu_stats_type          record_stats;
      logic [CNT_BITS-1:0]     emitted;
      int unsigned             mismatches;
      int unsigned             unexpected;
      int unsigned             ops_noted;
      int unsigned             beats_checked;
      int unsigned             records;
      int unsigned             run_flushes;

      function new();
         clear_record();
         mismatches    = 0;
         unexpected    = 0;
         ops_noted     = 0;
         beats_checked = 0;
         records       = 0;
         run_flushes   = 0;
      endfunction

      function void clear_record();
         run_open     = 1'b0;
         run_length   = '0;
         record_stats = '0;
         emitted      = '0;
      endfunction

      function void push_beat(input logic [OP_BITS-1:0] op, input logic [OUT_LEN_BITS-1:0] len,
                              input logic last);
         cmsu_beat_type b;
         emitted  = count_sat(emitted);
         b.op     = op;
         b.length = len;
         b.last   = last;
         b.stats  = record_stats;
         b.count  = emitted;
         expected_beats.push_back(b);
      endfunction

      // One accepted operation; statistics are updated before any result is queued.
      function void note_op(input logic [OP_BITS-1:0] op, input logic [OUT_LEN_BITS-1:0] len,
                            input logic last);
         ops_noted++;
         case (op)
            OP_M, OP_EQ, OP_X: begin
               record_stats.aligned_bases = sum_sat(record_stats.aligned_bases, len);
               record_stats.ref_span      = sum_sat(record_stats.ref_span, len);
            end
            OP_I: begin
               record_stats.aligned_bases = sum_sat(record_stats.aligned_bases, len);
               record_stats.gap_count     = count_sat(record_stats.gap_count);
            end
            OP_D: begin
               record_stats.ref_span  = sum_sat(record_stats.ref_span, len);
               record_stats.gap_count = count_sat(record_stats.gap_count);
            end
            OP_N: record_stats.ref_span = sum_sat(record_stats.ref_span, len);
            OP_S: record_stats.clipped_bases = sum_sat(record_stats.clipped_bases, len);
            OP_H: ;
            default: record_stats.odd_op_flag = 1'b1;
         endcase

         if (op == OP_EQ || op == OP_X) begin
            run_length = run_open ? len_sat(run_length, len) : len;
            run_open   = 1'b1;
            if (last) begin
               push_beat(OP_M, run_length, 1'b1);
            end
         end else begin
            if (run_open) begin
               push_beat(OP_M, run_length, 1'b0);
               run_flushes++;
               run_open   = 1'b0;
               run_length = '0;
            end
            push_beat(op, len, last);
         end

         if (last) begin
            records++;
            clear_record();
         end
      endfunction

      function void check_beat(input cmsu_beat_type got);
         cmsu_beat_type want;
         if (expected_beats.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("%0t: unexpected result: %s", $time, beat_text(got));
            return;
         end
         want = expected_beats.pop_front();
         beats_checked++;
         if (got.op !== want.op || got.length !== want.length || got.last !== want.last ||
             got.stats.aligned_bases !== want.stats.aligned_bases ||
             got.stats.ref_span !== want.stats.ref_span ||
             got.stats.gap_count !== want.stats.gap_count ||
             got.stats.clipped_bases !== want.stats.clipped_bases ||
             got.stats.odd_op_flag !== want.stats.odd_op_flag ||
             got.count !== want.count) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT) begin
               $display("%0t: result %0d mismatch", $time, beats_checked);
               $display("   expected %s", beat_text(want));
               $display("   actual   %s", beat_text(got));
            end
         end
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
// Testbench top: drives operation records into the merge unit and checks every result.
`timescale 1ns / 1ps
module tb_top;
   import cmsu_pkg::*;
   import cmsu_sb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_GAP    = QUEUE_DEPTH_DEF + 4;
   localparam int unsigned PHASE_ITEMS  = 360;
   localparam int unsigned LONG_OPS     = 120;
   localparam logic [OP_BITS-1:0] OP_TOP = {OP_BITS{1'b1}};

   logic clock = 1'b0;
   logic reset;

   cmsu_req_if req_chan ();
   cmsu_rsp_if rsp_chan ();

   cigar_merge_and_stats_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cigar_stats_scoreboard sb;
   cmsu_beat_type         seen_beat;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_stall_pct = 0;
   int unsigned           cycles = 0;
   bit                    hold_tag = 1'b0;
   bit                    hold_seen = 1'b0;
   int unsigned           hold_left = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  sb.expected_beats.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever hold_tag flips.
   always @(negedge clock) begin
      if (hold_tag != hold_seen) begin
         hold_seen = hold_tag;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Inputs are noted before results so a same-edge result always finds its expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            sb.note_op(req_chan.op_code, req_chan.op_length, req_chan.in_last);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            seen_beat.op                  = rsp_chan.out_op;
            seen_beat.length              = rsp_chan.out_length;
            seen_beat.last                = rsp_chan.out_last;
            seen_beat.stats.aligned_bases = rsp_chan.aligned_bases;
            seen_beat.stats.ref_span      = rsp_chan.ref_span;
            seen_beat.stats.gap_count     = rsp_chan.gap_count;
            seen_beat.stats.clipped_bases = rsp_chan.clipped_bases;
            seen_beat.stats.odd_op_flag   = rsp_chan.odd_op_flag;
            seen_beat.count               = rsp_chan.out_count;
            sb.check_beat(seen_beat);
         end
      end
   end

   // Called and returns at a falling edge; valid stays high for back-to-back transfers.
   task automatic send_op(input logic [OP_BITS-1:0] op, input logic [OUT_LEN_BITS-1:0] len,
                          input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op_code   <= op;
      req_chan.op_length <= len;
      req_chan.in_last   <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   function automatic logic [OP_BITS-1:0] pick_op(input bit noisy);
      int unsigned r;
      r = $urandom_range(99);
      if (noisy)   return OP_BITS'($urandom_range(OP_TOP));
      if (r < 30)  return $urandom_range(1) ? OP_EQ : OP_X;
      if (r < 45)  return OP_M;
      if (r < 55)  return OP_I;
      if (r < 65)  return OP_D;
      if (r < 72)  return OP_N;
      if (r < 80)  return OP_S;
      if (r < 86)  return OP_H;
      if (r < 90)  return OP_P;
      if (r < 95)  return OP_BITS'($urandom_range(OP_TOP, OP_X + 1));
      return OP_BITS'($urandom_range(OP_TOP));
   endfunction

   function automatic logic [OUT_LEN_BITS-1:0] pick_len(input bit heavy);
      int unsigned r;
      r = $urandom_range(99);
      if (heavy)
         return (r < 30) ? LEN_MAX : OUT_LEN_BITS'($urandom_range(LEN_MAX, LEN_MAX - 4096));
      if (r < 10) return '0;
      if (r < 50) return OUT_LEN_BITS'($urandom_range(255, 1));
      if (r < 55) return LEN_MAX;
      return OUT_LEN_BITS'($urandom & LEN_MAX);
   endfunction

   // Heavy records lean on one opcode with near-maximum lengths to push sums into saturation.
   task automatic send_record(inout int unsigned sent);
      int unsigned          n_ops;
      bit                   heavy;
      bit                   noisy;
      logic [OP_BITS-1:0]   favored;
      logic [OP_BITS-1:0]   op;
      heavy   = ($urandom_range(19) == 0);
      noisy   = ($urandom_range(9) == 0);
      n_ops   = heavy ? $urandom_range(60, 40) : $urandom_range(12, 1);
      favored = OP_BITS'($urandom_range(OP_X));
      for (int unsigned k = 0; k < n_ops; k++) begin
         op = (heavy && $urandom_range(1)) ? favored : pick_op(noisy);
         send_op(op, pick_len(heavy), k == n_ops - 1);
         sent++;
      end
   endtask

   task automatic run_records(input int unsigned min_items);
      int unsigned sent;
      sent = 0;
      while (sent < min_items) send_record(sent);
   endtask

   task automatic run_directed();
      send_op(OP_M, '0, 1'b0);
      send_op(OP_EQ, LEN_MAX, 1'b0);
      send_op(OP_X, LEN_MAX, 1'b0);          // merged length saturates
      send_op(OP_I, 28'd5, 1'b0);            // flush of the run plus the insert
      send_op(OP_D, 28'd7, 1'b0);
      send_op(OP_N, 28'h1234567, 1'b0);
      send_op(OP_S, LEN_MAX, 1'b0);
      send_op(OP_H, 28'd9, 1'b0);
      send_op(OP_P, 28'd3, 1'b0);
      send_op(OP_BITS'(OP_X + 1), 28'd1, 1'b0);
      send_op(OP_TOP, LEN_MAX, 1'b0);
      send_op(OP_M, 28'd2, 1'b0);            // true match stays apart from the run after it
      send_op(OP_EQ, 28'd1, 1'b0);
      send_op(OP_X, 28'd2, 1'b1);            // run closed by the last mark
      send_op(OP_X, '0, 1'b1);
      send_op(OP_BITS'(OP_X + 2), 28'd4, 1'b1);
      send_op(OP_H, 28'd1, 1'b1);
      send_op(OP_EQ, 28'd3, 1'b0);
      send_op(OP_D, 28'd2, 1'b1);
      send_op(OP_X, 28'd5, 1'b0);
      send_op(OP_EQ, 28'd6, 1'b0);
      send_op(OP_M, 28'd1, 1'b1);
   endtask

   // One record of long inserts and deletes that drives the aligned and span sums to saturation.
   task automatic run_long_record();
      logic [OP_BITS-1:0] op;
      for (int unsigned i = 0; i < LONG_OPS; i++) begin
         if (i % 40 == 39)  op = OP_S;
         else if (i[0])     op = OP_D;
         else               op = OP_I;
         send_op(op, OUT_LEN_BITS'($urandom_range(LEN_MAX, LEN_MAX / 2)), i == LONG_OPS - 1);
      end
   endtask

   initial begin
      int unsigned idle_by_phase[4];
      int unsigned stall_by_phase[4];
      idle_by_phase  = '{0, 54, 0, 8};
      stall_by_phase = '{0, 0, 54, 8};
      sb = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.op_code   = '0;
      req_chan.op_length = '0;
      req_chan.in_last   = 1'b0;
      rsp_chan.ready     = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      drain_results();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_by_phase[p];
         recv_stall_pct = stall_by_phase[p];
         if (p == 0)
            hold_tag = ~hold_tag;
         run_records(PHASE_ITEMS);
         drain_results();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_long_record();
      drain_results();

      $display("%0d operations in %0d records, %0d results checked, %0d merged runs flushed",
               sb.ops_noted, sb.records, sb.beats_checked, sb.run_flushes);
      $display("covered: all opcodes, run and sum saturation, idling and a long output hold-off");
      $display("%0d mismatches, %0d unexpected results, %0d outstanding",
               sb.mismatches, sb.unexpected, sb.expected_beats.size());
      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_beats.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/cmsu_pkg.sv
design/cmsu_if.sv
design/cmsu_front.sv
design/cmsu_queue.sv
design/cmsu_back.sv
design/cigar_merge_and_stats_unit.sv
design/cmsu_checker.sv
dv/cmsu_sb_pkg.sv
dv/tb_top.sv
